>>> sv/cslts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the camera / SLM / laser trigger sequencer.
// No dependencies; every other file but cslts_stream_if imports this package.
package cslts_pkg;

    // Default phase timer width in bits; the timer counts microseconds.
    localparam int TIMER_WIDTH_DEF = 20;

    // Widest duration register.
    localparam int DUR_W = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READOUT_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLM_PULSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_PULSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_FRAMES   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 3'd6;

    // Register reset values
    localparam logic [9:0]  CAMERA_PULSE_RST = 10'd10;
    localparam logic [15:0] READOUT_WAIT_RST = 16'd2151;
    localparam logic [15:0] SLM_PULSE_RST    = 16'd372;
    localparam logic [15:0] LIGHT_PULSE_RST  = 16'd999;
    localparam logic [15:0] FRAME_GAP_RST    = 16'd1250;
    localparam logic [7:0]  LIT_FRAMES_RST   = 8'd72;   // 8 x 9
    localparam logic [19:0] START_DELAY_RST  = 20'd1000000;

    // Stop characters
    localparam logic [7:0] STOP_LOWER = 8'h78;  // 'x'
    localparam logic [7:0] STOP_UPPER = 8'h58;  // 'X'

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_START = 2'd2
    } req_code_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_DELAY  = 4'd1,
        PH_CAM    = 4'd2,
        PH_WAIT   = 4'd3,
        PH_SLM    = 4'd4,
        PH_LIGHT  = 4'd5,
        PH_GAP    = 4'd6,
        PH_TCAM1  = 4'd7,
        PH_TWAIT1 = 4'd8,
        PH_TSLM1  = 4'd9,
        PH_TLED   = 4'd10,
        PH_TCAM2  = 4'd11,
        PH_TWAIT2 = 4'd12,
        PH_TSLM2  = 4'd13,
        PH_TDARK  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic camera_trigger;
        logic slm_trigger;
        logic laser_gate;
        logic test_led;
        logic sequence_start;
        logic running;
    } res_t;

    typedef struct packed {
        logic [9:0]  camera_pulse_us;
        logic [15:0] readout_wait_us;
        logic [15:0] slm_pulse_us;
        logic [15:0] light_pulse_us;
        logic [15:0] frame_gap_us;
        logic [7:0]  lit_frame_count;
        logic [19:0] start_delay_us;
    } cfg_t;

endpackage

>>> sv/cslts_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one request or result per handshake.
// Payload type is set per instance; no other dependencies.
interface cslts_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/cslts_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank for the trigger sequencer.
// Depends on cslts_pkg.
module cslts_cfg_regs
    import cslts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_pulse_us <= CAMERA_PULSE_RST;
            cfg_reg.readout_wait_us <= READOUT_WAIT_RST;
            cfg_reg.slm_pulse_us    <= SLM_PULSE_RST;
            cfg_reg.light_pulse_us  <= LIGHT_PULSE_RST;
            cfg_reg.frame_gap_us    <= FRAME_GAP_RST;
            cfg_reg.lit_frame_count <= LIT_FRAMES_RST;
            cfg_reg.start_delay_us  <= START_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA_PULSE: cfg_reg.camera_pulse_us <= cfg_wdata[9:0];
                CFG_READOUT_WAIT: cfg_reg.readout_wait_us <= cfg_wdata[15:0];
                CFG_SLM_PULSE:    cfg_reg.slm_pulse_us    <= cfg_wdata[15:0];
                CFG_LIGHT_PULSE:  cfg_reg.light_pulse_us  <= cfg_wdata[15:0];
                CFG_FRAME_GAP:    cfg_reg.frame_gap_us    <= cfg_wdata[15:0];
                CFG_LIT_FRAMES:   cfg_reg.lit_frame_count <= cfg_wdata[7:0];
                CFG_START_DELAY:  cfg_reg.start_delay_us  <= cfg_wdata[19:0];
                default:          ;  // unmapped index
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/cslts_seq_core.sv
`timescale 1ns / 1ps
// Phase sequencer: phase, timer, frame count, stop latch and start level.
// Depends on cslts_pkg.
module cslts_seq_core
    import cslts_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,       // request is taken this cycle
    input  req_t item,
    input  cfg_t cfg,
    output res_t res_next   // levels after the request
);

    localparam logic [32:0] TIMER_TOP = (33'd1 << TIMER_WIDTH) - 33'd1;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] frame_index;
        logic       stop_pending;
        logic       start_level;
    } seq_state_t;

    seq_state_t             st_reg, st_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;

    seq_state_t             cand;
    seq_state_t             fin;
    logic                   do_enter;
    logic                   skip;
    logic [DUR_W-1:0]       raw_len;
    logic [32:0]            ext_len;
    logic [TIMER_WIDTH-1:0] fin_len;

    // Phase after a finished phase, with its side effects.
    function automatic seq_state_t succ(input seq_state_t s, input logic [7:0] lit);
        seq_state_t r;
        r = s;
        case (s.phase)
            PH_DELAY:
            begin
                r.start_level = 1'b1;
                r.frame_index = '0;
                r.phase       = (lit == '0) ? PH_TCAM1 : PH_CAM;
            end
            PH_GAP:
            begin
                r.frame_index = s.frame_index + 8'd1;
                r.phase       = (r.frame_index >= lit) ? PH_TCAM1 : PH_CAM;
            end
            PH_TDARK:
            begin
                r.frame_index = '0;
                if (s.stop_pending)
                begin
                    r.stop_pending = 1'b0;
                    r.start_level  = 1'b0;
                    r.phase        = PH_IDLE;
                end
                else
                begin
                    r.phase = (lit == '0) ? PH_TCAM1 : PH_CAM;
                end
            end
            PH_CAM:    r.phase = PH_WAIT;
            PH_WAIT:   r.phase = PH_SLM;
            PH_SLM:    r.phase = PH_LIGHT;
            PH_LIGHT:  r.phase = PH_GAP;
            PH_TCAM1:  r.phase = PH_TWAIT1;
            PH_TWAIT1: r.phase = PH_TSLM1;
            PH_TSLM1:  r.phase = PH_TLED;
            PH_TLED:   r.phase = PH_TCAM2;
            PH_TCAM2:  r.phase = PH_TWAIT2;
            PH_TWAIT2: r.phase = PH_TSLM2;
            PH_TSLM2:  r.phase = PH_TDARK;
            default:
            begin
                r.start_level = 1'b0;
                r.frame_index = '0;
                r.phase       = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    // Request decode: candidate phase to enter, or a plain update.
    always_comb
    begin
        cand       = st_reg;
        do_enter   = 1'b0;
        st_next    = st_reg;
        timer_next = timer_reg;
        case (item.req_type)
            REQ_TICK:
            begin
                if (st_reg.phase != PH_IDLE)
                begin
                    if (timer_reg <= TIMER_WIDTH'(1))
                    begin
                        cand     = succ(st_reg, cfg.lit_frame_count);
                        do_enter = 1'b1;
                    end
                    else
                    begin
                        timer_next = timer_reg - TIMER_WIDTH'(1);
                    end
                end
            end
            REQ_BYTE:
            begin
                if (st_reg.phase != PH_IDLE && (item.rx_byte inside {STOP_LOWER, STOP_UPPER}))
                begin
                    st_next.stop_pending = 1'b1;
                end
            end
            REQ_START:
            begin
                if (st_reg.phase == PH_IDLE)
                begin
                    cand.phase        = PH_DELAY;
                    cand.frame_index  = '0;
                    cand.stop_pending = 1'b0;
                    cand.start_level  = 1'b0;
                    do_enter          = 1'b1;
                end
            end
            default: ;
        endcase
        if (do_enter)
        begin
            st_next    = fin;
            timer_next = fin_len;
        end
    end

    // Zero start delay or zero gap falls straight through to the next phase.
    assign skip = (cand.phase == PH_DELAY && cfg.start_delay_us == '0) ||
                  (cand.phase == PH_GAP && cfg.frame_gap_us == '0);
    assign fin  = skip ? succ(cand, cfg.lit_frame_count) : cand;

    // Length of the entered phase, read from its register now.
    always_comb
    begin
        case (fin.phase)
            PH_DELAY:                       raw_len = cfg.start_delay_us;
            PH_CAM, PH_TCAM1, PH_TCAM2:     raw_len = DUR_W'(cfg.camera_pulse_us);
            PH_WAIT, PH_TWAIT1, PH_TWAIT2:  raw_len = DUR_W'(cfg.readout_wait_us);
            PH_SLM, PH_TSLM1, PH_TSLM2:     raw_len = DUR_W'(cfg.slm_pulse_us);
            PH_LIGHT, PH_TLED, PH_TDARK:    raw_len = DUR_W'(cfg.light_pulse_us);
            PH_GAP:                         raw_len = DUR_W'(cfg.frame_gap_us);
            default:                        raw_len = '0;
        endcase
        // pulse and wait phases last at least one tick
        if (raw_len == '0 && fin.phase != PH_IDLE && fin.phase != PH_DELAY &&
            fin.phase != PH_GAP)
        begin
            raw_len = DUR_W'(1);
        end
        ext_len = 33'(raw_len);
        fin_len = (ext_len > TIMER_TOP) ? TIMER_TOP[TIMER_WIDTH-1:0]
                                        : ext_len[TIMER_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase        <= PH_IDLE;
            st_reg.frame_index  <= '0;
            st_reg.stop_pending <= 1'b0;
            st_reg.start_level  <= 1'b0;
            timer_reg           <= '0;
        end
        else if (adv)
        begin
            st_reg    <= st_next;
            timer_reg <= timer_next;
        end
    end

    always_comb
    begin
        res_next.camera_trigger = (st_next.phase == PH_CAM) ||
                                  (st_next.phase == PH_TCAM1) ||
                                  (st_next.phase == PH_TCAM2);
        res_next.slm_trigger    = (st_next.phase == PH_SLM);
        res_next.laser_gate     = (st_next.phase == PH_LIGHT);
        res_next.test_led       = (st_next.phase == PH_TLED);
        res_next.sequence_start = st_next.start_level;
        res_next.running        = (st_next.phase != PH_IDLE);
    end

endmodule

>>> sv/camera_slm_laser_trigger_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the camera / SLM / laser trigger sequencer.
// Depends on cslts_pkg, cslts_stream_if, cslts_cfg_regs and cslts_seq_core.

// Microsecond trigger sequencer. Each request on req is a one-microsecond
// tick, a received serial byte or a start request, and each one yields
// exactly one result on res: the trigger levels after that request. A start
// request while idle runs the start delay, then raises sequence_start and
// loops over bursts: lit_frame_count lit frames (camera pulse, readout wait,
// SLM pulse, laser pulse, dark gap), then one trailing frame with the test
// LED in place of the laser and one dark trailing frame. An 'x' or 'X' byte
// while running latches a stop, which takes effect when the current burst
// ends; all outputs then fall. Durations count ticks, not clocks; each is
// read from its register when its phase is entered, and anything beyond the
// phase timer range saturates. Zero start delay or gap is skipped, other zero
// durations count as one tick. Throughput is one request per clock while res
// is not stalled: a request is held in the input register, the phase logic
// runs between that register and the result register, and the result is
// registered there. Both registers have their own valid, so
// a new request is taken while a finished result still waits on res.ready.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and should be
// changed only while the block is idle.
module camera_slm_laser_trigger_sequencer_unit
    import cslts_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF  // 16 to 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    cslts_stream_if.sink          req,
    cslts_stream_if.source        res
);

    cfg_t cfg;
    res_t res_next;

    // input stage
    logic s1_valid_reg;
    req_t s1_item_reg;

    // result stage
    logic out_valid_reg;
    res_t out_data_reg;

    logic adv;   // request moves from input stage into result register

    assign adv       = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || adv;

    cslts_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cslts_seq_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item     (s1_item_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

endmodule

>>> sv/cslts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the trigger sequencer, bound to the top level.
// Depends on cslts_pkg and camera_slm_laser_trigger_sequencer_unit.
module cslts_checker
    import cslts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res_data
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // every accepted request is followed by a valid result on res
    a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 res_valid)
        else $error("accepted request produced no result");

    // empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled with empty result register");

    // at most one trigger at a time, and all low when not running
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0({res_data.camera_trigger, res_data.slm_trigger,
                                res_data.laser_gate, res_data.test_led}) &&
                      (res_data.running ||
                       !(res_data.camera_trigger || res_data.slm_trigger ||
                         res_data.laser_gate || res_data.test_led ||
                         res_data.sequence_start)))
        else $error("inconsistent trigger levels");

endmodule

bind camera_slm_laser_trigger_sequencer_unit cslts_checker u_cslts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
